// ===== rtl/core/sbps_pkg.sv =====
// ----------------------------------------------------------------------------
// sbps_pkg: shared types and helpers for the byte pattern search
// Constants, controller/datapath interface structs, FSM states, pattern and
// bad-character shift helpers.
// ----------------------------------------------------------------------------
package sbps_pkg;

   localparam int ALPHABET        = 256;
   localparam int BYTE_W          = $clog2(ALPHABET);
   localparam int PAT_BYTES       = 16;
   localparam int PAT_IDX_W       = $clog2(PAT_BYTES);
   localparam int LEN_W           = 5;
   localparam int POS_W           = 12;
   localparam int RSP_W           = 16;
   localparam int CSR_AW          = 5;
   localparam int CSR_DW          = 64;
   localparam int TEXT_DEPTH_DEF  = 4096;
   localparam int MAX_PATTERN_DEF = 16;

   // register index = paddr[4:3]
   localparam logic [1:0] REG_PAT_LOW  = 2'd0;
   localparam logic [1:0] REG_PAT_HIGH = 2'd1;
   localparam logic [1:0] REG_PAT_LEN  = 2'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD,
      ST_CMP,
      ST_LA,
      ST_SHIFT,
      ST_HIT,
      ST_MISS
   } state_type;

   typedef struct packed {
      logic restart;     // clear offset and compare index
      logic load;        // request accepted: store byte
      logic rd_la;       // read look-ahead byte instead of s + j
      logic j_inc;       // advance compare index
      logic shift;       // s += skip(look-ahead byte), j = 0
      logic emit;        // capture result, clear buffer
      logic emit_found;
   } cmd_type;

   typedef struct packed {
      logic byte_eq;     // text byte equals pattern byte j
      logic j_last;      // j == m - 1
      logic s_end;       // s + m >= n
      logic past_end;    // s + m > n
      logic out_busy;    // result register still occupied
   } status_type;

   function automatic logic [BYTE_W-1:0] pattern_byte(
      input logic [CSR_DW-1:0] lo,
      input logic [CSR_DW-1:0] hi,
      input logic [PAT_IDX_W-1:0] idx
   );
      logic [CSR_DW-1:0] word;
      word = idx[PAT_IDX_W-1] ? hi : lo;
      return word[idx[PAT_IDX_W-2:0]*BYTE_W +: BYTE_W];
   endfunction

   // Bad-character shift: m - (last position of c in pattern), else m + 1
   function automatic logic [LEN_W-1:0] skip_of(
      input logic [BYTE_W-1:0] c,
      input logic [CSR_DW-1:0] lo,
      input logic [CSR_DW-1:0] hi,
      input logic [LEN_W-1:0]  m
   );
      logic [LEN_W-1:0] sk;
      sk = m + LEN_W'(1);
      for (int i = 0; i < PAT_BYTES; i++) begin
         if ((LEN_W'(i) < m) && (pattern_byte(lo, hi, PAT_IDX_W'(i)) == c)) begin
            sk = m - LEN_W'(i);
         end
      end
      return sk;
   endfunction

endpackage

// ===== rtl/core/sbps_ram.sv =====
// ----------------------------------------------------------------------------
// sbps_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sbps_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbps_ctrl: search sequencer
// Loads text, then walks candidate offsets byte by byte, fetches look-ahead
// bytes and issues shifts until a hit or the end of the text.
// ----------------------------------------------------------------------------
module sbps_ctrl
   import sbps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) state_in = ST_RD;
         end
         ST_RD: begin
            state_in = sts.past_end ? ST_MISS : ST_CMP;
         end
         ST_CMP: begin
            priority if (sts.byte_eq && sts.j_last) state_in = ST_HIT;
            else if (sts.byte_eq)                   state_in = ST_RD;
            else if (sts.s_end)                     state_in = ST_MISS;
            else                                    state_in = ST_LA;
         end
         ST_LA:    state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_RD;
         ST_HIT, ST_MISS: begin
            if (!sts.out_busy) state_in = ST_LOAD;
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready  = 1'b1;
            cmd.restart = 1'b1;
            cmd.load    = req_tvalid;
         end
         ST_CMP: begin
            cmd.j_inc = sts.byte_eq && !sts.j_last;
         end
         ST_LA: begin
            cmd.rd_la = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         ST_HIT: begin
            cmd.emit       = !sts.out_busy;
            cmd.emit_found = 1'b1;
         end
         ST_MISS: begin
            cmd.emit = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/sbps_dp.sv =====
// ----------------------------------------------------------------------------
// sbps_dp: search datapath
// Text buffer, byte count, overflow flag, offset/index registers, shift
// logic and the result register.
// ----------------------------------------------------------------------------
module sbps_dp
   import sbps_pkg::*;
#(
   parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CSR_DW-1:0] pat_low,
   input  logic [CSR_DW-1:0] pat_high,
   input  logic [LEN_W-1:0]  pat_len,
   input  logic [BYTE_W-1:0] req_byte,
   input  cmd_type           cmd,
   output status_type        sts,
   output logic              rsp_tvalid,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              rsp_tready
);

   localparam int AW    = $clog2(TEXT_DEPTH);
   localparam int CNT_W = $clog2(TEXT_DEPTH + 1);
   localparam int J_W   = $clog2(MAX_PATTERN + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] s_ff, s_in;
   logic [J_W-1:0]   j_ff, j_in;
   logic             valid_ff, valid_in;
   logic             found_ff, found_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             oflag_ff, oflag_in;

   logic [LEN_W-1:0]  m_eff;
   logic [CNT_W:0]    s_plus_m;
   logic [CNT_W:0]    s_plus_j;
   logic [CNT_W:0]    s_plus_sk;
   logic [AW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              has_room;
   logic              wr_en;
   logic [CNT_W+POS_W-1:0] s_wide;

   // clamp length to 1..MAX_PATTERN
   always_comb begin
      priority if (pat_len == '0)                  m_eff = LEN_W'(1);
      else if (pat_len > LEN_W'(MAX_PATTERN))     m_eff = LEN_W'(MAX_PATTERN);
      else                                        m_eff = pat_len;
   end

   assign s_plus_m  = {1'b0, s_ff} + (CNT_W+1)'(m_eff);
   assign s_plus_j  = {1'b0, s_ff} + (CNT_W+1)'(j_ff);
   assign s_plus_sk = {1'b0, s_ff} + (CNT_W+1)'(skip_of(rd_data, pat_low, pat_high, m_eff));
   assign rd_addr   = cmd.rd_la ? s_plus_m[AW-1:0] : s_plus_j[AW-1:0];
   assign has_room  = count_ff < CNT_W'(TEXT_DEPTH);
   assign wr_en     = cmd.load && has_room;

   sbps_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TEXT_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.byte_eq  = rd_data == pattern_byte(pat_low, pat_high, PAT_IDX_W'(j_ff));
   assign sts.j_last   = LEN_W'(j_ff) == (m_eff - LEN_W'(1));
   assign sts.s_end    = s_plus_m >= {1'b0, count_ff};
   assign sts.past_end = s_plus_m > {1'b0, count_ff};
   assign sts.out_busy = valid_ff && !rsp_tready;

   assign s_wide = {{POS_W{1'b0}}, s_ff};

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      s_in     = s_ff;
      j_in     = j_ff;
      valid_in = valid_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      oflag_in = oflag_ff;

      if (wr_en) count_in = count_ff + CNT_W'(1);
      if (cmd.load && !has_room) ovf_in = 1'b1;

      if (cmd.restart) begin
         s_in = '0;
         j_in = '0;
      end else if (cmd.j_inc) begin
         j_in = j_ff + J_W'(1);
      end else if (cmd.shift) begin
         s_in = s_plus_sk[CNT_W-1:0];
         j_in = '0;
      end

      if (cmd.emit) begin
         valid_in = 1'b1;
         found_in = cmd.emit_found;
         pos_in   = cmd.emit_found ? s_wide[POS_W-1:0] : '0;
         oflag_in = ovf_ff;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         s_ff     <= '0;
         j_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         s_ff     <= s_in;
         j_ff     <= j_in;
         valid_ff <= valid_in;
      end
      found_ff <= found_in;
      pos_ff   <= pos_in;
      oflag_ff <= oflag_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_W'({oflag_ff, pos_ff, found_ff});

   // a hit is only reported for a candidate that fits in the text
   a_hit_in_text: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_found |-> !sts.past_end)
      else $error("hit reported past end of text");

   // buffer empties after every result
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> count_ff == '0 && !ovf_ff)
      else $error("buffer not cleared after result");

   // a result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(valid_ff && !rsp_tready))
      else $error("result overwritten");

   // buffered count never exceeds the buffer depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TEXT_DEPTH))
      else $error("text count beyond depth");

endmodule

// ===== rtl/core/sunday_byte_pattern_search_top.sv =====
// ----------------------------------------------------------------------------
// sunday_byte_pattern_search_top: Sunday quick-search byte pattern matcher
// Buffers a text stream and searches it for a configured 1..16 byte pattern.
// ----------------------------------------------------------------------------
// req_*  : text bytes, one request per cycle; tlast marks the final byte, after
//          which req_tready stays low until the search hands off its result.
// rsp_*  : one result per text: found, first match offset, overflow.
// csr_*  : APB-style; 0x00 pattern bytes 0..7, 0x08 bytes 8..15, 0x10 length.
//          Write only while idle.
// Search: one text RAM read port. A compared byte takes a read and a compare
//   state, a shift a look-ahead read and a skip add state.
// Bytes beyond TEXT_DEPTH are dropped and flagged in the result.
// Reset clears buffer count and overflow flag, keeps RAM contents, sets the
//   pattern length to 1. A stalled rsp_tready holds the result in its
//   register; the next text still loads, and its search waits only to hand
//   over its own result.
// ----------------------------------------------------------------------------
module sunday_byte_pattern_search_top
   import sbps_pkg::*;
#(
   parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] text_byte
   input  logic              req_tlast,   // last
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [0] found, [12:1] position, [13] overflow
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [CSR_DW-1:0] pat_low_ff, pat_high_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   logic              csr_wr;
   logic [1:0]        reg_idx;

   cmd_type    cmd;
   status_type sts;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_AW-1:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration registers; index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= LEN_W'(1);
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_PAT_LOW:  pat_low_ff  <= csr_pwdata;
            REG_PAT_HIGH: pat_high_ff <= csr_pwdata;
            REG_PAT_LEN:  pat_len_ff  <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PAT_LOW:  csr_prdata = pat_low_ff;
         REG_PAT_HIGH: csr_prdata = pat_high_ff;
         REG_PAT_LEN:  csr_prdata = CSR_DW'(pat_len_ff);
         default:      csr_prdata = '0;
      endcase
   end

   sbps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sbps_dp #(
      .TEXT_DEPTH  (TEXT_DEPTH),
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .pat_low    (pat_low_ff),
      .pat_high   (pat_high_ff),
      .pat_len    (pat_len_ff),
      .req_byte   (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tready (rsp_tready)
   );

endmodule

// ===== tb/sunday_byte_pattern_search_top_test.sv =====
// ----------------------------------------------------------------------------
// sunday_byte_pattern_search_top_test: self-checking bench for the matcher
// Streams texts into the block under a sequence of pattern settings, predicts
// found / position / overflow for each text and checks every result in order.
// Covers directed corner cases, random texts seeded with pattern copies, and
// random stalls on both streams.
// ----------------------------------------------------------------------------
module sunday_byte_pattern_search_top_test;
   import sbps_pkg::*;

   localparam int DEPTH          = TEXT_DEPTH_DEF;
   localparam int RANDOM_ITEMS   = 1130;
   localparam int QUIET_TAIL     = 150;   // last random requests run without idling
   localparam int SETTLE_CYCLES  = 16;    // after the last result before a CSR write
   localparam int LONG_STALL     = 400;   // receiver hold-off, in cycles
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last;
   } text_request_type;

   typedef struct packed {
      logic             overflow;
      logic [POS_W-1:0] position;
      logic             found;
   } search_outcome_type;

   // DUT ports, all inputs known from time zero
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata   = '0;
   logic              req_tlast   = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // shadow of the block: registers and text buffer
   logic [CSR_DW-1:0] pat_lo      = '0;
   logic [CSR_DW-1:0] pat_hi      = '0;
   logic [LEN_W-1:0]  pat_len_reg = LEN_W'(1);
   logic [7:0]        text_buf [DEPTH];
   int                text_len     = 0;
   bit                text_dropped = 1'b0;

   text_request_type   pending_bytes [$];     // requests waiting for the driver
   search_outcome_type search_outcomes [$];   // predicted results, oldest first

   // stimulus / flow control
   bit                idling_on     = 1'b0;
   bit                stall_armed   = 1'b0;
   bit                stall_done    = 1'b0;
   int                stall_left    = 0;
   int                send_gap      = 0;
   int                recv_gap      = 0;
   int                queued_count  = 0;
   int                mismatch_count = 0;

   text_request_type   next_request;
   search_outcome_type oldest_outcome;
   int                random_start;
   int                text_total;
   int                len_choice;
   int                room;
   logic [CSR_DW-1:0] lo_word;
   logic [CSR_DW-1:0] hi_word;
   logic [CSR_DW-1:0] len_word;
   logic [7:0]        fill_byte;

   sunday_byte_pattern_search_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // pattern byte idx as held in the shadow registers
   function automatic logic [7:0] pattern_at(input int idx);
      return (idx < 8) ? pat_lo[idx*8 +: 8] : pat_hi[(idx-8)*8 +: 8];
   endfunction

   // length register clamped to 1..16
   function automatic int active_length();
      int m;
      m = int'(pat_len_reg);
      if (m < 1) m = 1;
      if (m > MAX_PATTERN_DEF) m = MAX_PATTERN_DEF;
      return m;
   endfunction

   // Sunday quick search over the buffered text; overflow is filled by caller
   function automatic search_outcome_type quick_search();
      search_outcome_type r;
      logic [LEN_W-1:0]   shift_of [ALPHABET];
      int                 m;
      int                 n;
      int                 s;
      int                 j;
      int                 i;
      r = '0;
      m = active_length();
      n = text_len;
      for (i = 0; i < ALPHABET; i++) shift_of[i] = LEN_W'(m + 1);
      // later pattern positions overwrite earlier ones
      for (i = 0; i < m; i++) shift_of[pattern_at(i)] = LEN_W'(m - i);
      if (n < m) return r;   // short text
      s = 0;
      while (s + m <= n) begin
         j = 0;
         while (j < m && text_buf[s + j] == pattern_at(j)) j++;
         if (j >= m) begin
            r.found    = 1'b1;
            r.position = POS_W'(s);
            return r;
         end
         if (s + m >= n) break;   // look-ahead byte would lie past the text
         s += int'(shift_of[text_buf[s + m]]);
      end
      return r;
   endfunction

   // one accepted request: store or drop the byte, search on last
   task automatic absorb_request(input logic [7:0] b, input logic last);
      search_outcome_type r;
      if (text_len < DEPTH) begin
         text_buf[text_len] = b;
         text_len++;
      end else begin
         text_dropped = 1'b1;
      end
      if (last) begin
         r          = quick_search();
         r.overflow = text_dropped;
         search_outcomes.insert(search_outcomes.size(), r);
         text_len     = 0;
         text_dropped = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request driver: presents queued requests, random gaps between them
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_request(req_tdata, req_tlast);
         // slot is free when nothing is offered or the offer was just taken
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               next_request = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_request.text_byte;
               req_tlast  <= next_request.last;
               if (idling_on && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 9);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: checks each result against the oldest prediction and
   // drives rsp_tready with random bursts of back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (search_outcomes.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("result with nothing expected: found=%0d position=%0d overflow=%0d",
                           rsp_tdata[0], rsp_tdata[12:1], rsp_tdata[13]);
               mismatch_count++;
            end else begin
               oldest_outcome = search_outcomes.pop_front();
               if (rsp_tdata[0] !== oldest_outcome.found ||
                   rsp_tdata[12:1] !== oldest_outcome.position ||
                   rsp_tdata[13] !== oldest_outcome.overflow) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("mismatch: expected found=%0d position=%0d overflow=%0d, got found=%0d position=%0d overflow=%0d",
                              oldest_outcome.found, oldest_outcome.position,
                              oldest_outcome.overflow, rsp_tdata[0], rsp_tdata[12:1],
                              rsp_tdata[13]);
                  mismatch_count++;
               end
            end
         end
         // one long hold-off, counted here, so the block backs up its input
         if (stall_armed && !stall_done) begin
            stall_left = LONG_STALL;
            stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0)
               recv_gap = $urandom_range(1, 9);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic last);
      text_request_type t;
      t.text_byte = b;
      t.last      = last;
      pending_bytes.insert(pending_bytes.size(), t);
      queued_count++;
   endtask

   // wait until every request is taken and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || search_outcomes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write: setup, access, written when psel/penable/pwrite/pready high
   task automatic write_register(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_PAT_LOW:  pat_lo      = value;
         REG_PAT_HIGH: pat_hi      = value;
         REG_PAT_LEN:  pat_len_reg = value[LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_pattern(input logic [CSR_DW-1:0] lo, input logic [CSR_DW-1:0] hi,
                               input logic [CSR_DW-1:0] len);
      write_register(REG_PAT_LOW, lo);
      write_register(REG_PAT_HIGH, hi);
      write_register(REG_PAT_LEN, len);
   endtask

   // random text; dense texts draw mostly from the pattern's own bytes so
   // partial matches and small shifts are common; may embed a (broken) copy
   task automatic queue_random_text(input int len, input bit dense);
      logic [7:0] body [$];
      int         m;
      int         k;
      int         at;
      m = active_length();
      body = {};
      for (k = 0; k < len; k++) begin
         if (dense && $urandom_range(0, 7) != 0)
            body.insert(body.size(), pattern_at($urandom_range(0, m - 1)));
         else
            body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
      if (len >= m && $urandom_range(0, 1) == 1) begin
         at = $urandom_range(0, len - m);
         for (k = 0; k < m; k++) body[at + k] = pattern_at(k);
         if ($urandom_range(0, 3) == 0)
            body[at + $urandom_range(0, m - 1)] ^= 8'($urandom_range(1, 255));
      end
      for (k = 0; k < len; k++) push_byte(body[k], k == len - 1);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: pattern is a single zero byte
      push_byte(8'h00, 1'b1);                           // match at 0
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1);   // match at 1 after a shift
      push_byte(8'hFF, 1'b1);                           // look-ahead past the end
      push_byte(8'h7F, 1'b0); push_byte(8'h80, 1'b1);   // no match
      wait_idle();

      // three-byte pattern FF 00 FF, junk in the unused bytes
      load_pattern(64'hA5A5_A5A5_A5FF_00FF, '1, 64'd3);
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1);   // short text
      push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);   // match at 1
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFE, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
      wait_idle();

      // length zero acts as one
      load_pattern(64'h0000_0000_0000_0080, '0, 64'd0);
      push_byte(8'h80, 1'b1);
      wait_idle();

      // length 31 acts as 16; two bytes are a short text
      load_pattern('1, '1, 64'd31);
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
      wait_idle();

      // random phases: new settings, then a batch of texts
      random_start = queued_count;
      while (queued_count - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       len_choice = 0;
            1:       len_choice = 1;
            2, 3:    len_choice = 16;
            4:       len_choice = $urandom_range(17, 31);
            default: len_choice = $urandom_range(2, 15);
         endcase
         case ($urandom_range(0, 7))
            0: begin
               lo_word = '0;
               hi_word = '0;
            end
            1: begin
               lo_word = '1;
               hi_word = '1;
            end
            2, 3: begin
               // two-letter alphabet: repeats inside the pattern
               fill_byte = 8'($urandom_range(0, 254));
               for (int k = 0; k < 8; k++) begin
                  lo_word[k*8 +: 8] = fill_byte + 8'($urandom_range(0, 1));
                  hi_word[k*8 +: 8] = fill_byte + 8'($urandom_range(0, 1));
               end
            end
            default: begin
               lo_word = {$urandom, $urandom};
               hi_word = {$urandom, $urandom};
            end
         endcase
         // junk above the length field
         len_word = ({$urandom, $urandom} & ~64'h1F) | 64'(len_choice);
         load_pattern(lo_word, hi_word, len_word);

         idling_on = (queued_count - random_start < RANDOM_ITEMS - QUIET_TAIL) &&
                     ($urandom_range(0, 3) != 0);

         if (!stall_armed && queued_count - random_start > 300) begin
            // receiver holds off while many short texts pile up behind it
            stall_armed = 1'b1;
            for (int t = 0; t < 24; t++)
               queue_random_text($urandom_range(1, 6), 1'b1);
         end else begin
            text_total = $urandom_range(2, 10);
            for (int t = 0; t < text_total; t++) begin
               // keep the request total near its budget
               room = RANDOM_ITEMS - (queued_count - random_start);
               if (room > 0) begin
                  case ($urandom_range(0, 19))
                     0:       len_choice = $urandom_range(101, 400);
                     1, 2, 3: len_choice = $urandom_range(25, 100);
                     default: len_choice = $urandom_range(1, 24);
                  endcase
                  if (len_choice > room) len_choice = room;
                  queue_random_text(len_choice, $urandom_range(0, 2) != 0);
               end
            end
         end
         // sender waits here until every result of the batch is back
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/sbps_pkg.sv
rtl/core/sbps_ram.sv
rtl/core/sbps_ctrl.sv
rtl/core/sbps_dp.sv
rtl/core/sunday_byte_pattern_search_top.sv
tb/sunday_byte_pattern_search_top_test.sv
